// ----- rtl/arxsc_pkg.sv -----
// Types, constants and helper functions shared by the ARX stream cipher block.
`timescale 1ns / 1ps

package arxsc_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MIX_RD,
		ST_MIX_WR,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_KEY_RD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		ROT_NONE,
		ROT_10,
		ROT_27,
		ROT_8
	} rot_t;

	typedef struct packed {
		logic [3:0] dst;
		logic [3:0] src;
		logic       use_xor;
		rot_t       rot;
	} mix_op_t;

	localparam int ROT_AMT_10 = 10;
	localparam int ROT_AMT_27 = 27;
	localparam int ROT_AMT_8  = 8;

	localparam logic [3:0] LAST_STEP = 4'd8;
	localparam logic [2:0] LAST_MIX  = 3'd7;
	localparam logic [3:0] LAST_WORD = 4'd15;

	localparam logic [2:0] REG_KEY01 = 3'd0;
	localparam logic [2:0] REG_KEY23 = 3'd1;
	localparam logic [2:0] REG_KEY45 = 3'd2;
	localparam logic [2:0] REG_KEY67 = 3'd3;
	localparam logic [2:0] REG_NONCE = 3'd4;
	localparam logic [2:0] REG_MODE  = 3'd5;

	localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
	localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
	localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
	localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;
	localparam logic [31:0] TAU_0   = 32'h6170_7865;
	localparam logic [31:0] TAU_1   = 32'h3120_646e;
	localparam logic [31:0] TAU_2   = 32'h7962_2d36;
	localparam logic [31:0] TAU_3   = 32'h6b20_6574;

	// Word operation number step of mix number mix within one double round.
	function automatic mix_op_t mix_op(input logic [2:0] mix, input logic [3:0] step);
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] c;
		logic [3:0] d;
		logic [3:0] e;
		mix_op_t    r;
		unique case (mix)
			3'd0: begin a = 4'd0; b = 4'd4; c = 4'd8;  d = 4'd12; e = 4'd3; end
			3'd1: begin a = 4'd1; b = 4'd5; c = 4'd9;  d = 4'd13; e = 4'd0; end
			3'd2: begin a = 4'd2; b = 4'd6; c = 4'd10; d = 4'd14; e = 4'd1; end
			3'd3: begin a = 4'd3; b = 4'd7; c = 4'd11; d = 4'd15; e = 4'd2; end
			3'd4: begin a = 4'd0; b = 4'd5; c = 4'd10; d = 4'd15; e = 4'd3; end
			3'd5: begin a = 4'd1; b = 4'd6; c = 4'd11; d = 4'd12; e = 4'd0; end
			3'd6: begin a = 4'd2; b = 4'd7; c = 4'd8;  d = 4'd13; e = 4'd1; end
			3'd7: begin a = 4'd3; b = 4'd4; c = 4'd9;  d = 4'd14; e = 4'd2; end
		endcase
		unique case (step)
			4'd0:    r = '{dst: d, src: e, use_xor: 1'b0, rot: ROT_NONE};
			4'd1:    r = '{dst: c, src: d, use_xor: 1'b1, rot: ROT_NONE};
			4'd2:    r = '{dst: b, src: c, use_xor: 1'b0, rot: ROT_10};
			4'd3:    r = '{dst: a, src: b, use_xor: 1'b0, rot: ROT_NONE};
			4'd4:    r = '{dst: e, src: a, use_xor: 1'b1, rot: ROT_NONE};
			4'd5:    r = '{dst: d, src: e, use_xor: 1'b0, rot: ROT_27};
			4'd6:    r = '{dst: c, src: d, use_xor: 1'b0, rot: ROT_NONE};
			4'd7:    r = '{dst: b, src: c, use_xor: 1'b1, rot: ROT_NONE};
			4'd8:    r = '{dst: a, src: b, use_xor: 1'b0, rot: ROT_8};
			default: r = '{dst: a, src: a, use_xor: 1'b0, rot: ROT_NONE};
		endcase
		return r;
	endfunction

	// Input word idx of a block, built from the key, counter, nonce and mode.
	function automatic logic [31:0] init_word(
		input logic [3:0]  idx,
		input logic [63:0] key01,
		input logic [63:0] key23,
		input logic [63:0] key45,
		input logic [63:0] key67,
		input logic [63:0] nonce,
		input logic [63:0] counter,
		input logic        long_mode
	);
		logic [31:0] w;
		unique case (idx)
			4'd0:  w = key01[31:0];
			4'd1:  w = key01[63:32];
			4'd2:  w = key23[31:0];
			4'd3:  w = key23[63:32];
			4'd4:  w = counter[31:0];
			4'd5:  w = counter[63:32];
			4'd6:  w = long_mode ? SIGMA_0 : TAU_0;
			4'd7:  w = long_mode ? SIGMA_1 : TAU_1;
			4'd8:  w = long_mode ? key45[31:0]  : key01[31:0];
			4'd9:  w = long_mode ? key45[63:32] : key01[63:32];
			4'd10: w = long_mode ? key67[31:0]  : key23[31:0];
			4'd11: w = long_mode ? key67[63:32] : key23[63:32];
			4'd12: w = nonce[31:0];
			4'd13: w = nonce[63:32];
			4'd14: w = long_mode ? SIGMA_2 : TAU_2;
			4'd15: w = long_mode ? SIGMA_3 : TAU_3;
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/arx_stream_cipher_xor.sv -----
// Byte-serial ARX stream cipher: keystream generation and XOR with the message.
//
// Channel   Direction  Content
// s_axis    in         tdata = data_byte, tuser = first_of_call
// m_axis    out        tdata = out_byte
// apb       in/out     key words, nonce and key mode registers at 8*index
//
// A byte from the current keystream block is accepted, then emitted.
// A byte that starts a block first runs the shared 32-bit add/xor/rotate unit:
// it loads the 16 input words, runs each word operation of ROUND_COUNT rounds as a
// read and a write, adds the input words back the same way and reads the byte's word.
// Reset clears control state, keys and nonce, sets long mode; state memory is kept.
// A waiting result stalls only the emit step; no byte is accepted during that stall.
`timescale 1ns / 1ps

module arx_stream_cipher_xor #(
	parameter int ROUND_COUNT = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] first_of_call
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	import arxsc_pkg::*;

	localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
	localparam logic [RW-1:0] LAST_ROUND = RW'(ROUND_COUNT - 1);

	state_t        state_q;
	state_t        state_d;
	logic [63:0]   key01_q;
	logic [63:0]   key23_q;
	logic [63:0]   key45_q;
	logic [63:0]   key67_q;
	logic [63:0]   nonce_q;
	logic          long_mode_q;
	logic [63:0]   counter_q;
	logic [5:0]    pos_q;
	logic          block_valid_q;
	logic [3:0]    idx_q;
	logic [3:0]    step_q;
	logic [2:0]    mix_q;
	logic [RW-1:0] round_q;
	logic [7:0]    byte_q;
	logic [7:0]    out_data_q;
	logic          out_valid_q;
	logic [31:0]   state_mem [16];
	logic [31:0]   rd_a_q;
	logic [31:0]   rd_b_q;
	logic [3:0]    rd_addr_a;
	logic [3:0]    wr_addr;
	logic [31:0]   wr_data;
	logic          mem_we;
	logic          emit_fire;
	logic          cfg_write;
	logic          last_op;
	mix_op_t       op;
	logic [31:0]   init_w;
	logic [31:0]   opnd_b;
	logic [31:0]   alu_pre;
	logic [31:0]   alu_out;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[5:3])
			REG_KEY01: prdata = key01_q;
			REG_KEY23: prdata = key23_q;
			REG_KEY45: prdata = key45_q;
			REG_KEY67: prdata = key67_q;
			REG_NONCE: prdata = nonce_q;
			REG_MODE:  prdata = {63'd0, long_mode_q};
			default:   prdata = 64'd0;
		endcase
	end

	assign op      = mix_op(mix_q, step_q);
	assign last_op = (step_q == LAST_STEP) && (mix_q == LAST_MIX) && (round_q == LAST_ROUND);
	assign init_w  = init_word(idx_q, key01_q, key23_q, key45_q, key67_q, nonce_q,
		counter_q, long_mode_q);

	// Shared word unit: add or xor, then an optional fixed rotation.
	assign opnd_b  = (state_q == ST_ADD_WR) ? init_w : rd_b_q;
	assign alu_pre = (state_q == ST_MIX_WR && op.use_xor) ? (rd_a_q ^ opnd_b)
		: (rd_a_q + opnd_b);

	always_comb begin
		unique case ((state_q == ST_MIX_WR) ? op.rot : ROT_NONE)
			ROT_NONE: alu_out = alu_pre;
			ROT_10:   alu_out = (alu_pre << ROT_AMT_10) | (alu_pre >> (32 - ROT_AMT_10));
			ROT_27:   alu_out = (alu_pre << ROT_AMT_27) | (alu_pre >> (32 - ROT_AMT_27));
			ROT_8:    alu_out = (alu_pre << ROT_AMT_8) | (alu_pre >> (32 - ROT_AMT_8));
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		wr_addr       = idx_q;
		wr_data       = alu_out;
		rd_addr_a     = pos_q[5:2];
		emit_fire     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = (s_axis_tuser || !block_valid_q) ? ST_LOAD : ST_EMIT;
				end
			end
			ST_LOAD: begin
				mem_we  = 1'b1;
				wr_data = init_w;
				if (idx_q == LAST_WORD) begin
					state_d = ST_MIX_RD;
				end
			end
			ST_MIX_RD: begin
				rd_addr_a = op.dst;
				state_d   = ST_MIX_WR;
			end
			ST_MIX_WR: begin
				mem_we  = 1'b1;
				wr_addr = op.dst;
				state_d = last_op ? ST_ADD_RD : ST_MIX_RD;
			end
			ST_ADD_RD: begin
				rd_addr_a = idx_q;
				state_d   = ST_ADD_WR;
			end
			ST_ADD_WR: begin
				mem_we  = 1'b1;
				state_d = (idx_q == LAST_WORD) ? ST_KEY_RD : ST_ADD_RD;
			end
			ST_KEY_RD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || m_axis_tready) begin
					emit_fire = 1'b1;
					state_d   = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			state_mem[wr_addr] <= wr_data;
		end
		rd_a_q <= state_mem[rd_addr_a];
		rd_b_q <= state_mem[op.src];
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_q <= s_axis_tdata;
		end
		if (emit_fire) begin
			out_data_q <= byte_q ^ rd_a_q[{pos_q[1:0], 3'b000} +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q       <= '0;
			key23_q       <= '0;
			key45_q       <= '0;
			key67_q       <= '0;
			nonce_q       <= '0;
			long_mode_q   <= 1'b1;
			counter_q     <= '0;
			pos_q         <= '0;
			block_valid_q <= 1'b0;
			idx_q         <= '0;
			step_q        <= '0;
			mix_q         <= '0;
			round_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (paddr[5:3])
					REG_KEY01: key01_q <= pwdata;
					REG_KEY23: key23_q <= pwdata;
					REG_KEY45: key45_q <= pwdata;
					REG_KEY67: key67_q <= pwdata;
					REG_NONCE: begin
						nonce_q   <= pwdata;
						counter_q <= '0;
					end
					REG_MODE:  long_mode_q <= pwdata[0];
					default: ;
				endcase
			end
			if (state_q == ST_IDLE && s_axis_tvalid && (s_axis_tuser || !block_valid_q)) begin
				pos_q         <= '0;
				block_valid_q <= 1'b1;
				idx_q         <= '0;
				step_q        <= '0;
				mix_q         <= '0;
				round_q       <= '0;
			end
			if (state_q == ST_LOAD || state_q == ST_ADD_WR) begin
				idx_q <= idx_q + 4'd1;
			end
			if (state_q == ST_ADD_WR && idx_q == LAST_WORD) begin
				counter_q <= counter_q + 64'd1;
			end
			if (state_q == ST_MIX_WR) begin
				if (step_q == LAST_STEP) begin
					step_q <= '0;
					mix_q  <= mix_q + 3'd1;
					if (mix_q == LAST_MIX) begin
						round_q <= round_q + RW'(1);
					end
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
				pos_q       <= pos_q + 6'd1;
				if (pos_q == 6'd63) begin
					block_valid_q <= 1'b0;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD_WR && idx_q == LAST_WORD && !cfg_write)
		|=> counter_q == $past(counter_q) + 64'd1)
		else $error("Block counter did not advance by one after a block.");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX_RD || state_q == ST_MIX_WR) |-> round_q <= LAST_ROUND)
		else $error("Round counter ran past the last round.");

	a_emit_has_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> block_valid_q)
		else $error("Keystream byte used without a valid block.");

	a_block_used_up: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && pos_q == 6'd63) |=> (!block_valid_q && pos_q == 6'd0))
		else $error("Block still marked valid after its last byte.");

endmodule
